### rtl/core/epm_pkg.sv
package epm_pkg;

	localparam int NUM_CHANNELS = 8;
	localparam int CH_W = 3;
	localparam int FRAME_LEN = 256;
	localparam int FIDX_W = 8;
	localparam int MEM_AW = 16;
	localparam int MIX_SHIFT = 9;
	localparam logic [6:0] FULL_VOLUME = 7'd64;
	localparam logic [16:0] MAX_LENGTH = 17'd65536;

	typedef enum logic [2:0] {
		KIND_WRITE  = 3'd0,
		KIND_PLAY   = 3'd1,
		KIND_CLEAR  = 3'd2,
		KIND_FRAME  = 3'd3,
		KIND_MIX    = 3'd4,
		KIND_STATUS = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FRAME,
		ST_MIX_RD,
		ST_MIX_ACC,
		ST_OUT
	} state_t;

endpackage

### rtl/core/eight_channel_pcm_mixer_core.sv
// Eight-channel PCM sample mixer.
// Input stream s_axis_* carries one request per beat; kind in tuser selects
// write sample, play, clear, frame start, mix or status. Every request gives
// exactly one result beat on m_axis_* (mixed sample, granted channel, active
// count, remaining length).
// Write, play, clear and status pass from acceptance through the ST_OUT state into the output register.
// Frame start walks the eight channels, one per cycle.
// Mix reads the sample memory once per channel through its single read port,
// one read issued per cycle and accumulated in the cycle after.
// One request is in work at a time; a new one is taken once the previous
// result has moved into the output register.
// Reset clears all channels, frame latches and the frame index. The sample
// memory is not cleared; samples must be written before they are played.
// When the receiver stalls, the result holds in the output register; one more
// request can be taken, and it then waits in ST_OUT until the result is taken.
module eight_channel_pcm_mixer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// address[15:0], length[32:16], volume[39:33], sample_byte[47:40], channel[50:48]
	input  logic [55:0] s_axis_tdata,
	// kind[2:0]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// mixed_sample[7:0], granted_channel[11:8], active_count[15:12], remaining[33:16]
	output logic [39:0] m_axis_tdata
);
	import epm_pkg::*;

	logic [7:0]  mem [0:(1<<MEM_AW)-1];
	logic [7:0]  mem_rd_q;

	logic [16:0] cursor_q [NUM_CHANNELS];
	logic [17:0] end_q    [NUM_CHANNELS];
	logic [6:0]  vol_q    [NUM_CHANNELS];
	logic [16:0] base_q   [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] active_q, fvalid_q;
	logic [FIDX_W-1:0] fidx_q;

	state_t state_q, state_d;
	logic [2:0]  kind_q;
	logic [55:0] req_q;
	logic [CH_W-1:0] ch_q;
	logic [CH_W-1:0] rd_ch_q;
	logic        rd_vld_q;
	logic signed [19:0] acc_q;
	logic [39:0] out_q;
	logic        out_vld_q;

	logic [15:0] r_addr;
	logic [16:0] r_len, len_sat;
	logic [6:0]  r_vol, vol_sat;
	logic [7:0]  r_byte;
	logic [CH_W-1:0] r_chan;
	logic        s_acc, done;
	logic [3:0]  grant;
	logic        any_free;
	logic [3:0]  cnt;
	logic [16:0] cur_next;
	logic [15:0] mix_addr;
	logic signed [19:0] prod, acc_sum;
	logic signed [10:0] shifted;
	logic [7:0]  mix_sat;
	logic [17:0] rem;
	logic [39:0] res_d;

	assign r_addr = req_q[15:0];
	assign r_len  = req_q[32:16];
	assign r_vol  = req_q[39:33];
	assign r_byte = req_q[47:40];
	assign r_chan = req_q[50:48];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign done  = (state_q == ST_OUT) && (!out_vld_q || m_axis_tready);
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					case (kind_t'(s_axis_tuser))
						KIND_FRAME: state_d = ST_FRAME;
						KIND_MIX:   state_d = ST_MIX_RD;
						default:    state_d = ST_OUT;
					endcase
				end
			end
			ST_FRAME:   if (ch_q == CH_W'(NUM_CHANNELS-1)) state_d = ST_OUT;
			ST_MIX_RD:  if (ch_q == CH_W'(NUM_CHANNELS-1)) state_d = ST_MIX_ACC;
			ST_MIX_ACC: state_d = ST_OUT;
			ST_OUT:     if (done) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// first idle channel and active count
	always_comb begin
		grant = 4'(NUM_CHANNELS);
		any_free = 1'b0;
		cnt = '0;
		for (int i = NUM_CHANNELS-1; i >= 0; i--) begin
			if (!active_q[i]) begin
				grant = 4'(i);
				any_free = 1'b1;
			end
		end
		for (int i = 0; i < NUM_CHANNELS; i++) cnt = cnt + 4'(active_q[i]);
	end

	assign len_sat  = (r_len > MAX_LENGTH) ? MAX_LENGTH : r_len;
	assign vol_sat  = (r_vol > FULL_VOLUME) ? FULL_VOLUME : r_vol;
	assign cur_next = cursor_q[ch_q] + 17'(FRAME_LEN);
	assign mix_addr = base_q[ch_q][15:0] + 16'(fidx_q);
	assign prod     = 20'($signed(mem_rd_q)) * $signed({13'd0, vol_q[rd_ch_q]});
	assign acc_sum  = acc_q + ((rd_vld_q && fvalid_q[rd_ch_q]) ? prod : 20'sd0);
	assign shifted  = 11'(acc_q >>> MIX_SHIFT);
	assign mix_sat  = (shifted > 11'sd127) ? 8'h7f :
	                  (shifted < -11'sd128) ? 8'h80 : shifted[7:0];
	assign rem      = (active_q[r_chan]) ?
	                  (end_q[r_chan] - {1'b0, cursor_q[r_chan]}) : '0;

	// result fields for the request in work
	always_comb begin
		res_d = '0;
		res_d[15:12] = cnt;
		res_d[11:8]  = 4'(NUM_CHANNELS);
		case (kind_t'(kind_q))
			KIND_MIX:    res_d[7:0] = mix_sat;
			KIND_PLAY: begin
				res_d[11:8]  = grant;
				res_d[15:12] = cnt + 4'(any_free);
			end
			KIND_CLEAR:  res_d[15:12] = '0;
			KIND_STATUS: res_d[33:16] = rem;
			default: ;
		endcase
	end

	// sample memory port
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && done && kind_q == KIND_WRITE)
			mem[r_addr] <= r_byte;
		mem_rd_q <= mem[mix_addr];
	end

	// channel state and frame walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			active_q  <= '0;
			fvalid_q  <= '0;
			fidx_q    <= '0;
			ch_q      <= '0;
			rd_ch_q   <= '0;
			rd_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				cursor_q[i] <= '0;
				end_q[i]    <= '0;
				vol_q[i]    <= '0;
				base_q[i]   <= '0;
			end
		end else begin
			state_q <= state_d;
			if (done) out_vld_q <= 1'b1;
			else if (out_vld_q && m_axis_tready) out_vld_q <= 1'b0;
			rd_ch_q  <= ch_q;
			rd_vld_q <= (state_q == ST_MIX_RD);
			if (s_acc) begin
				ch_q <= '0;
			end else if (state_q == ST_FRAME || state_q == ST_MIX_RD) begin
				ch_q <= ch_q + 1'b1;
			end
			if (state_q == ST_FRAME) begin
				fvalid_q[ch_q] <= active_q[ch_q];
				if (active_q[ch_q]) begin
					base_q[ch_q]   <= cursor_q[ch_q];
					cursor_q[ch_q] <= cur_next;
					if ($signed({1'b0, cur_next}) >= $signed(end_q[ch_q]))
						active_q[ch_q] <= 1'b0;
				end
				fidx_q <= '0;
			end
			if (done) begin
				case (kind_t'(kind_q))
					KIND_PLAY: begin
						if (any_free) begin
							active_q[grant[CH_W-1:0]] <= 1'b1;
							cursor_q[grant[CH_W-1:0]] <= {1'b0, r_addr};
							end_q[grant[CH_W-1:0]]    <= 18'({2'b0, r_addr})
								+ 18'(len_sat) - 18'(FRAME_LEN);
							vol_q[grant[CH_W-1:0]]    <= vol_sat;
						end
					end
					KIND_CLEAR: active_q <= '0;
					KIND_MIX:   fidx_q <= fidx_q + 1'b1;
					default: ;
				endcase
			end
		end
	end

	// request capture, accumulate and result register
	always_ff @(posedge clk) begin
		if (s_acc) begin
			kind_q <= s_axis_tuser;
			req_q  <= s_axis_tdata;
			acc_q  <= '0;
		end else if (state_q == ST_MIX_RD || state_q == ST_MIX_ACC) begin
			acc_q <= acc_sum;
		end
		if (done)
			out_q <= res_d;
	end

endmodule

### rtl/core/epm_checker.sv
module epm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata
);
	import epm_pkg::*;

	// hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// active count stays in range
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[15:12] <= 4'(NUM_CHANNELS))
		else $error("active count out of range");

	// one request in work: no accept the cycle after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while busy");

	// granted channel never above none-free code
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[11:8] <= 4'(NUM_CHANNELS))
		else $error("granted channel out of range");

endmodule

bind eight_channel_pcm_mixer_core epm_checker u_epm_checker (.*);
